// File: rtl/core/spu_pkg.sv
package spu_pkg;

  localparam int MAX_LEN = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = 32;
  localparam int OUT_W   = 31;
  // running sum: one element per entry plus the minus-one offset, with headroom
  localparam int SUM_W   = VAL_W + LEN_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SUM_START = -(SUM_W'(65536));
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    vec_end;
  } spu_item_t;

endpackage

// File: rtl/core/spu_front.sv
module spu_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [spu_pkg::VAL_W-1:0]  in_element_value,
  input  logic                              in_is_last,
  input  logic                              q_full,
  output logic                              q_push,
  output spu_pkg::spu_item_t                q_item
);

  logic [spu_pkg::IDX_W-1:0] cnt_r;
  logic [spu_pkg::IDX_W-1:0] cnt_nxt;
  logic                      vec_end;

  // a full vector ends even without the last flag
  assign vec_end  = in_is_last || (cnt_r == spu_pkg::IDX_W'(spu_pkg::MAX_LEN - 1));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_item   = '{value: in_element_value, vec_end: vec_end};

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = vec_end ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/spu_queue.sv
module spu_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spu_pkg::spu_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output spu_pkg::spu_item_t pop_item
);

  spu_pkg::spu_item_t           buf_r [spu_pkg::QUEUE_DEPTH];
  logic [spu_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [spu_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [spu_pkg::QUEUE_CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == spu_pkg::QUEUE_CW'(spu_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == spu_pkg::QUEUE_AW'(spu_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == spu_pkg::QUEUE_AW'(spu_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/spu_div.sv
module spu_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [spu_pkg::SUM_W-1:0]  num,
  input  logic [spu_pkg::LEN_W-1:0]         den,
  output logic                              done,
  output logic signed [spu_pkg::SUM_W-1:0]  quo
);

  localparam int CNT_W = $clog2(spu_pkg::SUM_W + 1);

  logic [spu_pkg::SUM_W-1:0] mag_r, mag_nxt;
  logic [spu_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [spu_pkg::LEN_W-1:0] den_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [spu_pkg::LEN_W:0]   trial;
  logic                      fits;

  assign trial = {rem_r, mag_r[spu_pkg::SUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign done  = done_r;
  // truncate toward zero: divide magnitudes, then restore the sign
  assign quo   = neg_r ? -$signed(mag_r) : $signed(mag_r);

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = num[spu_pkg::SUM_W-1] ? spu_pkg::SUM_W'(-num) : spu_pkg::SUM_W'(num);
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(spu_pkg::SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? spu_pkg::LEN_W'(trial - {1'b0, den_r}) : trial[spu_pkg::LEN_W-1:0];
      mag_nxt = {mag_r[spu_pkg::SUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= num[spu_pkg::SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// File: rtl/core/spu_back.sv
module spu_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  spu_pkg::spu_item_t                q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spu_pkg::OUT_W-1:0]         out_projected_value,
  output logic                              out_last_out
);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_ADD  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_OUT  = 6'b100000
  } spu_state_t;

  spu_state_t state_r, state_nxt;

  logic signed [spu_pkg::VAL_W-1:0] vec_mem_r [spu_pkg::MAX_LEN];
  logic signed [spu_pkg::VAL_W-1:0] srt_r   [spu_pkg::MAX_LEN];
  logic signed [spu_pkg::VAL_W-1:0] srt_nxt [spu_pkg::MAX_LEN];
  logic [spu_pkg::MAX_LEN-1:0]      ge;

  logic [spu_pkg::LEN_W-1:0]        cnt_r, cnt_nxt;
  logic [spu_pkg::LEN_W-1:0]        n_r, n_nxt;
  logic [spu_pkg::LEN_W-1:0]        k_r, k_nxt;
  logic [spu_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [spu_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic signed [spu_pkg::SUM_W-1:0] thr_r, thr_nxt;
  logic signed [spu_pkg::VAL_W-1:0] rd_r;

  logic                             div_start;
  logic                             div_done;
  logic signed [spu_pkg::SUM_W-1:0] div_quo;
  logic signed [spu_pkg::SUM_W-1:0] sum_add;
  logic signed [spu_pkg::SUM_W:0]   diff;
  logic                             is_final;

  spu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_add),
    .den   (k_r + 1'b1),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_pop     = (state_r == ST_LOAD) && q_not_empty;
  assign sum_add   = sum_r + spu_pkg::SUM_W'(srt_r[0]);
  assign div_start = (state_r == ST_ADD);
  assign is_final  = ({1'b0, idx_r} == spu_pkg::LEN_W'(n_r - 1'b1));

  assign diff = (spu_pkg::SUM_W + 1)'(rd_r) - (spu_pkg::SUM_W + 1)'(thr_r);
  assign out_valid    = (state_r == ST_OUT);
  assign out_last_out = is_final;
  always_comb begin
    if (diff[spu_pkg::SUM_W]) begin
      out_projected_value = '0;
    end else if (diff > (spu_pkg::SUM_W + 1)'(spu_pkg::OUT_MAX)) begin
      out_projected_value = spu_pkg::OUT_MAX;
    end else begin
      out_projected_value = diff[spu_pkg::OUT_W-1:0];
    end
  end

  // insertion into the descending sorted row: entries past the fill count rank lowest
  always_comb begin
    for (int i = 0; i < spu_pkg::MAX_LEN; i++) begin
      ge[i] = (spu_pkg::LEN_W'(i) < cnt_r) && (srt_r[i] >= q_item.value);
    end
    for (int i = 0; i < spu_pkg::MAX_LEN; i++) begin
      srt_nxt[i] = srt_r[i];
      if (state_r == ST_LOAD && q_not_empty) begin
        if (ge[i]) begin
          srt_nxt[i] = srt_r[i];
        end else if (i == 0) begin
          srt_nxt[i] = q_item.value;
        end else if (ge[i-1]) begin
          srt_nxt[i] = q_item.value;
        end else begin
          srt_nxt[i] = srt_r[i-1];
        end
      end else if (state_r == ST_ADD) begin
        // advance the row so the next smaller element sits at the head
        if (i < spu_pkg::MAX_LEN - 1) begin
          srt_nxt[i] = srt_r[i+1];
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    thr_nxt   = thr_r;
    case (state_r)
      ST_LOAD: begin
        if (q_not_empty) begin
          cnt_nxt = cnt_r + 1'b1;
          if (q_item.vec_end) begin
            n_nxt     = cnt_r + 1'b1;
            cnt_nxt   = '0;
            k_nxt     = '0;
            sum_nxt   = spu_pkg::SUM_START;
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        sum_nxt   = sum_add;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          thr_nxt   = div_quo;
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (k_r == n_r || thr_r >= spu_pkg::SUM_W'(srt_r[0])) begin
          idx_nxt   = '0;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_ADD;
        end
      end
      ST_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (is_final) begin
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      vec_mem_r[cnt_r[spu_pkg::IDX_W-1:0]] <= q_item.value;
    end
    if (state_r == ST_RD) begin
      rd_r <= vec_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < spu_pkg::MAX_LEN; i++) begin
      srt_r[i] <= srt_nxt[i];
    end
    sum_r <= sum_nxt;
    thr_r <= thr_nxt;
    n_r   <= n_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// File: rtl/core/simplex_projection_unit.sv
// Projects a vector of signed Q16.16 elements onto the probability simplex. Send one element per
// transaction; a vector ends at in_is_last or at its 16th element. Elements load one a cycle,
// while the back end is in its load state, through a two-entry queue, and each is inserted into
// a sorted row as it arrives. At the end of a vector the threshold search runs: for each of the
// k largest elements tried it does an add, a bit-serial divide and a check. Results then follow
// in input order, with out_last_out on the final one. Input keeps being taken until the queue
// fills.
module simplex_projection_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [spu_pkg::VAL_W-1:0]  in_element_value,
  input  logic                              in_is_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spu_pkg::OUT_W-1:0]         out_projected_value,
  output logic                              out_last_out
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_not_empty;
  spu_pkg::spu_item_t q_in_item;
  spu_pkg::spu_item_t q_out_item;

  spu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .in_is_last       (in_is_last),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_in_item)
  );

  spu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out_item)
  );

  spu_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_item              (q_out_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_projected_value (out_projected_value),
    .out_last_out        (out_last_out)
  );

`ifndef SYNTHESIS
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_pop)
    else $error("back loads while results are pending");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_out) |=> !out_valid)
    else $error("result after end of vector");

  a_queue_push_safe: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");
`endif

endmodule
